// File: src/tmhq_pkg.sv
// Shared types and constants for the ternary max-heap priority queue.
// Used by every module of the block but tmhq_ram; depends on nothing.
`default_nettype none

package tmhq_pkg;

    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 6;
    localparam int STATUS_W = 2;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic                      func;
        logic signed [VALUE_W-1:0] new_value;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] removed_value;
        logic signed [VALUE_W-1:0] top_value;
        logic                      top_valid;
        logic [COUNT_W-1:0]        entry_count;
        logic [STATUS_W-1:0]       status;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_UP_RD,
        S_UP_CMP,
        S_PUT,
        S_RM_ROOT,
        S_RM_LAST,
        S_DN_FIRST,
        S_DN_CHILD,
        S_DN_DEC,
        S_TOP_RD,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath, at most one set per cycle.
    typedef struct packed {
        logic ld_item;
        logic start;
        logic up_rd;
        logic up_cmp;
        logic put;
        logic rm_root;
        logic rm_last;
        logic dn_first;
        logic dn_child;
        logic dn_dec;
        logic top_rd;
        logic done;
    } t_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic is_remove;
        logic full;
        logic empty;
        logic up_swap;
        logic up_root;
        logic last_gone;
        logic no_child;
        logic more_child;
        logic dn_swap;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// File: src/ternary_max_heap_queue.sv
// Top level of the ternary max-heap priority queue.
// Depends on tmhq_pkg, tmhq_ctrl and tmhq_dp (which holds tmhq_ram).
`default_nettype none

// Priority queue of signed 32-bit values kept as a 3-ary max-heap in a single
// RAM of CAPACITY entries. Each input item either inserts new_value or removes
// the maximum, and produces exactly one result item carrying the removed value,
// the new maximum, the entry count and a status (ok, full with the insert
// dropped, or empty). Items are handled one at a time: the input is ready only
// while the sequencer is idle, and a finished result waits in an output
// register so that the next item can be taken while it is still unclaimed.
// The heap RAM has one read port with a registered read, and that port sets
// the pace. An insert into an empty heap writes its value at the root; any
// other insert reads each parent in turn, and every compare that swaps lifts
// the value one level. A removal that empties the heap goes straight on to
// the result; any other removal moves the last entry to the root and sinks it
// level by level (one read per child, then a compare and write) until a
// compare leaves it in place or it has no children. Failed operations on a
// full or empty queue also go straight on to the result. The heap store needs
// no clearing after reset, since only entries below the count are ever used.
module ternary_max_heap_queue #(
    parameter int CAPACITY = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire tmhq_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output tmhq_pkg::t_out_item      o_out_item
);

    tmhq_pkg::t_cmd  cmd;
    tmhq_pkg::t_stat stat;

    // The controller only sequences; all storage and comparisons live in the datapath.
    tmhq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tmhq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

// File: src/tmhq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; holds no package references.
`default_nettype none

module tmhq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: src/tmhq_ctrl.sv
// Sequencing state machine of the heap queue: walks each operation step by step.
// Depends on tmhq_pkg for the state, command and status types.
`default_nettype none

module tmhq_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire tmhq_pkg::t_stat i_stat,
    output tmhq_pkg::t_cmd      o_cmd
);

    tmhq_pkg::t_state r_state;
    tmhq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tmhq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tmhq_pkg::S_IDLE: begin
                if (i_in_valid) n_state = tmhq_pkg::S_START;
            end
            tmhq_pkg::S_START: begin
                if (i_stat.is_remove) begin
                    n_state = i_stat.empty ? tmhq_pkg::S_TOP_RD : tmhq_pkg::S_RM_ROOT;
                end else if (i_stat.full) begin
                    n_state = tmhq_pkg::S_TOP_RD;
                end else if (i_stat.empty) begin
                    n_state = tmhq_pkg::S_PUT;
                end else begin
                    n_state = tmhq_pkg::S_UP_RD;
                end
            end
            tmhq_pkg::S_UP_RD: begin
                n_state = tmhq_pkg::S_UP_CMP;
            end
            tmhq_pkg::S_UP_CMP: begin
                if (i_stat.up_swap && !i_stat.up_root) begin
                    n_state = tmhq_pkg::S_UP_RD;
                end else begin
                    n_state = tmhq_pkg::S_PUT;
                end
            end
            tmhq_pkg::S_PUT: begin
                n_state = tmhq_pkg::S_TOP_RD;
            end
            tmhq_pkg::S_RM_ROOT: begin
                n_state = i_stat.last_gone ? tmhq_pkg::S_TOP_RD : tmhq_pkg::S_RM_LAST;
            end
            tmhq_pkg::S_RM_LAST: begin
                n_state = tmhq_pkg::S_DN_FIRST;
            end
            tmhq_pkg::S_DN_FIRST: begin
                n_state = i_stat.no_child ? tmhq_pkg::S_PUT : tmhq_pkg::S_DN_CHILD;
            end
            tmhq_pkg::S_DN_CHILD: begin
                if (!i_stat.more_child) n_state = tmhq_pkg::S_DN_DEC;
            end
            tmhq_pkg::S_DN_DEC: begin
                n_state = i_stat.dn_swap ? tmhq_pkg::S_DN_FIRST : tmhq_pkg::S_PUT;
            end
            tmhq_pkg::S_TOP_RD: begin
                n_state = tmhq_pkg::S_DONE;
            end
            tmhq_pkg::S_DONE: begin
                if (i_stat.out_free) n_state = tmhq_pkg::S_IDLE;
            end
            default: begin
                n_state = tmhq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            tmhq_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.ld_item = i_in_valid;
            end
            tmhq_pkg::S_START:    o_cmd.start    = 1'b1;
            tmhq_pkg::S_UP_RD:    o_cmd.up_rd    = 1'b1;
            tmhq_pkg::S_UP_CMP:   o_cmd.up_cmp   = 1'b1;
            tmhq_pkg::S_PUT:      o_cmd.put      = 1'b1;
            tmhq_pkg::S_RM_ROOT:  o_cmd.rm_root  = 1'b1;
            tmhq_pkg::S_RM_LAST:  o_cmd.rm_last  = 1'b1;
            tmhq_pkg::S_DN_FIRST: o_cmd.dn_first = 1'b1;
            tmhq_pkg::S_DN_CHILD: o_cmd.dn_child = 1'b1;
            tmhq_pkg::S_DN_DEC:   o_cmd.dn_dec   = 1'b1;
            tmhq_pkg::S_TOP_RD:   o_cmd.top_rd   = 1'b1;
            tmhq_pkg::S_DONE:     o_cmd.done     = 1'b1;
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: src/tmhq_dp.sv
// Datapath of the heap queue: heap RAM, moving value, hole index, count and result register.
// Depends on tmhq_pkg and tmhq_ram.
`default_nettype none

module tmhq_dp #(
    parameter int CAPACITY = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire tmhq_pkg::t_in_item  i_in_item,
    input  wire tmhq_pkg::t_cmd      i_cmd,
    output tmhq_pkg::t_stat          o_stat,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output tmhq_pkg::t_out_item      o_out_item
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = AW + 2;
    // Division by three as a multiply by a rounded-up reciprocal; exact for AW-bit operands.
    localparam int DS = AW + 2;
    localparam int DM = ((1 << DS) + 2) / 3;
    localparam int PW = AW + DS;

    logic                             r_func;
    logic signed [tmhq_pkg::VALUE_W-1:0] r_val;
    logic        [AW-1:0]             r_hole;
    logic        [CW-1:0]             r_count;
    logic        [XW-1:0]             r_child;
    logic                             r_have_best;
    logic signed [tmhq_pkg::VALUE_W-1:0] r_best_val;
    logic        [AW-1:0]             r_best_idx;
    logic signed [tmhq_pkg::VALUE_W-1:0] r_removed;
    logic        [tmhq_pkg::STATUS_W-1:0] r_status;
    logic                             r_out_valid;
    tmhq_pkg::t_out_item              r_out;

    logic                             ram_we;
    logic        [AW-1:0]             ram_waddr;
    logic        [tmhq_pkg::VALUE_W-1:0] ram_wdata;
    logic                             ram_re;
    logic        [AW-1:0]             ram_raddr;
    logic        [tmhq_pkg::VALUE_W-1:0] ram_rdata;
    logic signed [tmhq_pkg::VALUE_W-1:0] rd_val;

    logic        [AW-1:0]             hole_m1;
    logic        [PW-1:0]             parent_prod;
    logic        [AW-1:0]             parent_idx;
    logic        [XW-1:0]             first_child;
    logic        [XW-1:0]             next_child;
    logic        [XW-1:0]             count_x;
    logic        [CW-1:0]             count_m1;
    logic                             out_free;
    logic                             take_child;

    tmhq_ram #(
        .WIDTH (tmhq_pkg::VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_val      = $signed(ram_rdata);
    assign hole_m1     = r_hole - AW'(1);
    assign parent_prod = PW'(hole_m1) * PW'(DM);
    assign parent_idx  = parent_prod[PW-1:DS];
    assign first_child = (XW'(r_hole) << 1) + XW'(r_hole) + XW'(1);
    assign next_child  = r_child + XW'(1);
    assign count_x     = XW'(r_count);
    assign count_m1    = r_count - CW'(1);
    assign out_free    = !r_out_valid || i_out_ready;
    assign take_child  = !r_have_best || (rd_val > r_best_val);

    always_comb begin
        o_stat.is_remove  = (r_func == tmhq_pkg::FUNC_REMOVE);
        o_stat.full       = (r_count == CW'(CAPACITY));
        o_stat.empty      = (r_count == '0);
        o_stat.up_swap    = (rd_val < r_val);
        o_stat.up_root    = (r_best_idx == '0);
        o_stat.last_gone  = (r_count == CW'(1));
        o_stat.no_child   = (first_child >= count_x);
        o_stat.more_child = (next_child < count_x) && (next_child <= first_child + XW'(2));
        o_stat.dn_swap    = (r_val < r_best_val);
        o_stat.out_free   = out_free;
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_hole;
        ram_wdata = r_val;
        ram_re    = 1'b0;
        ram_raddr = '0;
        if (i_cmd.up_cmp && o_stat.up_swap) begin
            ram_we    = 1'b1;
            ram_wdata = rd_val;
        end
        if (i_cmd.put) begin
            ram_we = 1'b1;
        end
        if (i_cmd.dn_dec && o_stat.dn_swap) begin
            ram_we    = 1'b1;
            ram_wdata = r_best_val;
        end
        if (i_cmd.start || i_cmd.top_rd) begin
            ram_re = 1'b1;
        end
        if (i_cmd.up_rd) begin
            ram_re    = 1'b1;
            ram_raddr = parent_idx;
        end
        if (i_cmd.rm_root) begin
            ram_re    = 1'b1;
            ram_raddr = count_m1[AW-1:0];
        end
        if (i_cmd.dn_first) begin
            ram_re    = !o_stat.no_child;
            ram_raddr = first_child[AW-1:0];
        end
        if (i_cmd.dn_child) begin
            ram_re    = o_stat.more_child;
            ram_raddr = next_child[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.start && !o_stat.is_remove && !o_stat.full) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.rm_root) begin
                r_count <= count_m1;
            end
            if (i_cmd.done && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_item) begin
            r_func    <= i_in_item.func;
            r_val     <= i_in_item.new_value;
            r_removed <= '0;
            r_status  <= tmhq_pkg::STATUS_OK;
        end
        if (i_cmd.start) begin
            r_hole <= r_count[AW-1:0];
            if (o_stat.is_remove && o_stat.empty) begin
                r_status <= tmhq_pkg::STATUS_EMPTY;
            end else if (!o_stat.is_remove && o_stat.full) begin
                r_status <= tmhq_pkg::STATUS_FULL;
            end
        end
        if (i_cmd.up_rd) begin
            r_best_idx <= parent_idx;
        end
        if (i_cmd.up_cmp && o_stat.up_swap) begin
            r_hole <= r_best_idx;
        end
        if (i_cmd.rm_root) begin
            r_removed <= rd_val;
        end
        if (i_cmd.rm_last) begin
            r_val  <= rd_val;
            r_hole <= '0;
        end
        if (i_cmd.dn_first) begin
            r_child     <= first_child;
            r_have_best <= 1'b0;
        end
        if (i_cmd.dn_child) begin
            r_have_best <= 1'b1;
            if (take_child) begin
                r_best_val <= rd_val;
                r_best_idx <= r_child[AW-1:0];
            end
            if (o_stat.more_child) begin
                r_child <= next_child;
            end
        end
        if (i_cmd.dn_dec && o_stat.dn_swap) begin
            r_hole <= r_best_idx;
        end
        if (i_cmd.done && out_free) begin
            r_out.removed_value <= r_removed;
            r_out.top_value     <= o_stat.empty ? '0 : rd_val;
            r_out.top_valid     <= !o_stat.empty;
            r_out.entry_count   <= tmhq_pkg::COUNT_W'(r_count);
            r_out.status        <= r_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

// File: src/tmhq_checker.sv
// Port-level checks for the heap queue, bound to the top level.
// Depends on tmhq_pkg and ternary_max_heap_queue.
`default_nettype none

module tmhq_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_ready,
    input wire tmhq_pkg::t_in_item  i_in_item,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire tmhq_pkg::t_out_item o_out_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result item dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_item))
        else $error("stalled result item changed");

    a_empty_view: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.top_valid |->
            o_out_item.entry_count == '0 && o_out_item.top_value == '0)
        else $error("empty heap reported with entries or a maximum");

    a_empty_removal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == tmhq_pkg::STATUS_EMPTY |->
            o_out_item.removed_value == '0 && !o_out_item.top_valid)
        else $error("removal from an empty heap returned data");

    a_full_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == tmhq_pkg::STATUS_FULL |->
            o_out_item.removed_value == '0 && o_out_item.top_valid)
        else $error("dropped insert reported an empty heap or a removal");

endmodule

bind ternary_max_heap_queue tmhq_checker u_tmhq_checker (.*);

`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for the ternary max-heap priority queue.
// Depends on tmhq_pkg and ternary_max_heap_queue; it keeps its own mirror of the heap
// and checks every result item against it.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY     = 32;
    localparam int RANDOM_ITEMS = 830;
    localparam int LONG_STALL   = 300;
    // This drain time is well above the slowest removal, which leaves a wide margin.
    localparam int SETTLE_CYCLES = 60;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                in_valid = 1'b0;
    tmhq_pkg::t_in_item  in_item = '0;
    logic                out_ready = 1'b0;
    logic                in_ready;
    logic                out_valid;
    tmhq_pkg::t_out_item out_item;

    // Items waiting for the driver, and the results that the heap mirror predicts.
    tmhq_pkg::t_in_item  pending_ops[$];
    tmhq_pkg::t_out_item expected_results[$];

    // The mirror of the heap contents and its entry count.
    logic signed [tmhq_pkg::VALUE_W-1:0] heap_mirror [CAPACITY];
    int unsigned                         heap_size = 0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic long_stall_req = 1'b0;
    int   stall_left = 0;

    int fail_count = 0;
    int accepted_ops = 0;
    int checked_results = 0;
    int full_hits = 0;
    int empty_hits = 0;
    int queued_ops = 0;
    int gen_count = 0;

    ternary_max_heap_queue #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    always #2 i_clk = ~i_clk;

    // Applies one heap operation to the mirror and returns the result item that the
    // block must produce for it. An insert climbs while its parent is strictly smaller;
    // a removal moves the last entry to the root and sinks it toward the largest child,
    // taking the leftmost child when two or three children are equal.
    function automatic tmhq_pkg::t_out_item predict_heap_op(tmhq_pkg::t_in_item op);
        tmhq_pkg::t_out_item                 res;
        int unsigned                         k;
        int unsigned                         parent;
        int unsigned                         first;
        int unsigned                         best;
        int unsigned                         c;
        logic signed [tmhq_pkg::VALUE_W-1:0] tmp;
        res = '0;
        res.status = tmhq_pkg::STATUS_OK;
        if (op.func == tmhq_pkg::FUNC_INSERT) begin
            if (heap_size >= CAPACITY) begin
                res.status = tmhq_pkg::STATUS_FULL;
            end else begin
                heap_mirror[heap_size] = op.new_value;
                k = heap_size;
                heap_size++;
                while (k > 0) begin
                    parent = (k - 1) / 3;
                    if (heap_mirror[parent] >= heap_mirror[k]) break;
                    tmp = heap_mirror[parent];
                    heap_mirror[parent] = heap_mirror[k];
                    heap_mirror[k] = tmp;
                    k = parent;
                end
            end
        end else if (heap_size == 0) begin
            res.status = tmhq_pkg::STATUS_EMPTY;
        end else begin
            res.removed_value = heap_mirror[0];
            heap_size--;
            heap_mirror[0] = heap_mirror[heap_size];
            k = 0;
            forever begin
                first = 3 * k + 1;
                if (first >= heap_size) break;
                best = first;
                for (c = first + 1; c <= first + 2 && c < heap_size; c++) begin
                    if (heap_mirror[c] > heap_mirror[best]) best = c;
                end
                if (heap_mirror[k] >= heap_mirror[best]) break;
                tmp = heap_mirror[best];
                heap_mirror[best] = heap_mirror[k];
                heap_mirror[k] = tmp;
                k = best;
            end
        end
        if (heap_size > 0) begin
            res.top_value = heap_mirror[0];
            res.top_valid = 1'b1;
        end
        res.entry_count = tmhq_pkg::COUNT_W'(heap_size);
        return res;
    endfunction

    // The driver offers the oldest pending item. A new item is only loaded once the
    // current one has been taken, so the payload holds steady while valid is high.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                in_item  <= pending_ops.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // The receiver stalls at random, and on request holds off for a long stretch so
    // that the block fills its output register and then refuses further items.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (long_stall_req && stall_left == 0) begin
            stall_left <= LONG_STALL;
            out_ready  <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // The monitor predicts on every accepted input item and checks every accepted
    // result item against the oldest prediction.
    always @(posedge i_clk) begin
        tmhq_pkg::t_out_item want;
        if (i_rst_n) begin
            if (in_valid && in_ready) begin
                want = predict_heap_op(in_item);
                if (want.status == tmhq_pkg::STATUS_FULL) full_hits++;
                if (want.status == tmhq_pkg::STATUS_EMPTY) empty_hits++;
                expected_results.push_back(want);
                accepted_ops++;
            end
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result item with no item outstanding: %p", out_item);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    checked_results++;
                    if (out_item.removed_value !== want.removed_value) begin
                        $error("removed_value: expected %0d, got %0d",
                               want.removed_value, out_item.removed_value);
                        fail_count++;
                    end
                    if (out_item.top_value !== want.top_value) begin
                        $error("top_value: expected %0d, got %0d",
                               want.top_value, out_item.top_value);
                        fail_count++;
                    end
                    if (out_item.top_valid !== want.top_valid) begin
                        $error("top_valid: expected %0b, got %0b",
                               want.top_valid, out_item.top_valid);
                        fail_count++;
                    end
                    if (out_item.entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, out_item.entry_count);
                        fail_count++;
                    end
                    if (out_item.status !== want.status) begin
                        $error("status: expected %0d, got %0d",
                               want.status, out_item.status);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Queues one operation for the driver. The generator keeps a rough count of its own
    // so that bursts can aim at a full or an empty heap.
    task automatic push_op(input logic func,
                           input logic signed [tmhq_pkg::VALUE_W-1:0] value);
        tmhq_pkg::t_in_item op;
        op.func = func;
        op.new_value = value;
        pending_ops.push_back(op);
        queued_ops++;
        if (func == tmhq_pkg::FUNC_INSERT && gen_count < CAPACITY) gen_count++;
        if (func == tmhq_pkg::FUNC_REMOVE && gen_count > 0) gen_count--;
    endtask

    // Values mix the full range with a narrow band, where ties are common, and with
    // the two extremes of the signed range.
    function automatic logic signed [tmhq_pkg::VALUE_W-1:0] random_value();
        case ($urandom_range(9))
            5, 6:    return $signed($urandom_range(15)) - 8;
            7:       return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            8:       return 32'sh7FFF_FFFF - $urandom_range(3);
            9:       return 32'sh8000_0000 + $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    // One burst of random items: fill the heap and push past full, drain it and remove
    // past empty, or a mixed run of inserts and removals.
    task automatic run_burst();
        int n;
        case ($urandom_range(3))
            0: begin
                while (gen_count < CAPACITY) push_op(tmhq_pkg::FUNC_INSERT, random_value());
                repeat ($urandom_range(1, 3)) push_op(tmhq_pkg::FUNC_INSERT, random_value());
            end
            1: begin
                while (gen_count > 0) push_op(tmhq_pkg::FUNC_REMOVE, '0);
                repeat ($urandom_range(1, 2)) push_op(tmhq_pkg::FUNC_REMOVE, random_value());
            end
            default: begin
                n = $urandom_range(10, 40);
                repeat (n) begin
                    if ($urandom_range(99) < 55) begin
                        push_op(tmhq_pkg::FUNC_INSERT, random_value());
                    end else begin
                        push_op(tmhq_pkg::FUNC_REMOVE, random_value());
                    end
                end
            end
        endcase
    endtask

    // Waits until every queued item has been taken and every predicted result has come.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0);
    endtask

    // Main sequence. All control variables change at the falling edge, away from the
    // rising edge where the driver, receiver and monitor sample them.
    initial begin
        int phase_goal;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: removal from an empty heap, the extremes of the value range,
        // equal values, and a full drain that ends in another empty removal.
        push_op(tmhq_pkg::FUNC_REMOVE, 32'sh7FFF_FFFF);
        push_op(tmhq_pkg::FUNC_INSERT, 32'sh0000_0000);
        push_op(tmhq_pkg::FUNC_INSERT, 32'sh8000_0000);
        push_op(tmhq_pkg::FUNC_INSERT, 32'sh7FFF_FFFF);
        push_op(tmhq_pkg::FUNC_INSERT, -32'sd1);
        push_op(tmhq_pkg::FUNC_INSERT, 32'sd1);
        push_op(tmhq_pkg::FUNC_INSERT, 32'sd5);
        push_op(tmhq_pkg::FUNC_INSERT, 32'sd5);
        push_op(tmhq_pkg::FUNC_INSERT, 32'sd5);
        push_op(tmhq_pkg::FUNC_INSERT, 32'sh5555_5555);
        push_op(tmhq_pkg::FUNC_INSERT, 32'shAAAA_AAAA);
        push_op(tmhq_pkg::FUNC_INSERT, 32'sh7FFF_FFFF);
        repeat (11) push_op(tmhq_pkg::FUNC_REMOVE, 32'sh0000_0000);
        push_op(tmhq_pkg::FUNC_REMOVE, -32'sd1);
        wait_drained();

        // Random part in three stretches: a slow receiver, then a slow sender, then
        // neither idles. Some bursts end with the sender paused until all results are in.
        phase_goal = queued_ops;
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 61 : 0;
            recv_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 14 : 0;
            phase_goal += RANDOM_ITEMS / 3;
            if (phase == 2) begin
                // Keep plenty of items on offer while the receiver holds off for a long
                // time, so that the block backs up and stops taking new items.
                repeat (3) run_burst();
                long_stall_req = 1'b1;
                @(negedge i_clk);
                long_stall_req = 1'b0;
            end
            while (queued_ops < phase_goal) begin
                run_burst();
                if ($urandom_range(3) == 0) wait_drained();
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        $display("Ran %0d heap operations and checked %0d result items.",
                 accepted_ops, checked_results);
        $display("Inserts dropped on a full heap: %0d; removals from an empty heap: %0d.",
                 full_hits, empty_hits);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Safety net against a hung handshake.
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
